### hw/rtl/dsdaf_pkg.sv
`timescale 1ns / 1ps

package dsdaf_pkg;

  localparam int unsigned FIELD_W   = 10;
  localparam int unsigned DIGITS    = 4;
  localparam int unsigned BCD_W     = 4 * DIGITS;
  localparam int unsigned MSG_LEN   = 16;
  localparam int unsigned IDX_W     = $clog2(MSG_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_LEN - 1);

  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef struct packed {
    logic [FIELD_W-1:0] first_sample;
    logic [FIELD_W-1:0] second_sample;
  } sample_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_message;
  } result_t;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] digits;
  } lane_stat_t;

  function automatic logic [7:0] digit_char(logic [3:0] digit);
    return CHAR_ZERO | {4'b0000, digit};
  endfunction

  // byte of the message at a given position; digits are packed thousands first
  function automatic logic [7:0] msg_byte(logic [IDX_W-1:0] idx, logic [BCD_W-1:0] da,
                                          logic [BCD_W-1:0] db);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = CHAR_AT;
      4'd1:    ch = CHAR_S;
      4'd2:    ch = CHAR_P;
      4'd3:    ch = CHAR_S;
      4'd4:    ch = CHAR_SPACE;
      4'd5:    ch = digit_char(da[15:12]);
      4'd6:    ch = digit_char(da[11:8]);
      4'd7:    ch = digit_char(da[7:4]);
      4'd8:    ch = digit_char(da[3:0]);
      4'd9:    ch = CHAR_SPACE;
      4'd10:   ch = digit_char(db[15:12]);
      4'd11:   ch = digit_char(db[11:8]);
      4'd12:   ch = digit_char(db[7:4]);
      4'd13:   ch = digit_char(db[3:0]);
      4'd14:   ch = CHAR_CR;
      default: ch = CHAR_LF;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/dsdaf_lane.sv
`timescale 1ns / 1ps

module dsdaf_lane import dsdaf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  take_i,
  output logic                  full_o,
  output lane_stat_t            stat_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic                  full_q, full_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      adj;

  // shift-and-add-3: fix up every digit before each shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
    end
  end

  always_comb begin
    full_d = full_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (load_i) begin
      full_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      bin_d  = value_i;
      bcd_d  = '0;
    end else begin
      if (take_i) begin
        full_d = 1'b0;
      end
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CNT_W'(1);
        bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
        bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      full_q <= full_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign full_o        = full_q;
  assign stat_o.done   = full_q && (cnt_q == '0);
  assign stat_o.digits = bcd_q;

endmodule

### hw/rtl/dsdaf_frame.sv
`timescale 1ns / 1ps

module dsdaf_frame import dsdaf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  lane_stat_t lane_a_i,
  input  lane_stat_t lane_b_i,
  output logic       ready_o,
  output logic       result_valid_o,
  output result_t    result_o
);

  logic             active_q, active_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q;
  logic [BCD_W-1:0] dig_a_q, dig_b_q;
  result_t          result_q;

  logic last;
  assign last    = (idx_q == LAST_IDX);
  assign ready_o = !active_q || last;

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    if (load_i) begin
      active_d = 1'b1;
      idx_d    = '0;
    end else if (active_q) begin
      idx_d = idx_q + IDX_W'(1);
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      valid_q  <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dig_a_q <= lane_a_i.digits;
      dig_b_q <= lane_b_i.digits;
    end
    result_q.out_byte       <= msg_byte(idx_q, dig_a_q, dig_b_q);
    result_q.end_of_message <= last;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

### hw/rtl/dual_sample_decimal_ascii_framer.sv
`timescale 1ns / 1ps

// Sample pair to ASCII message framer.
// Input: a command is taken at a clock edge where start is high and busy is
// low; sample_i carries both samples for that transfer.
// Output: sixteen bytes "@SPS aaaa bbbb<CR><LF>" appear one per cycle on
// result_o, each marked by result_valid_o for a single cycle; end_of_message
// is set on the LF byte. The receiver has no way to hold the stream off.
// Two conversion lanes turn the samples to four BCD digits each, one bit per
// cycle, and then hand them to the message stage.
// The first byte is registered and put on the outputs once both lanes are
// done and the message stage has taken their digits.
// The message stage sends one byte per cycle; the lanes take the next pair
// while the current message is still going out, and messages follow each
// other without a gap when the next pair has been converted in time.
// Reset clears the lanes and the message stage; nothing is sent until the
// first command.
module dual_sample_decimal_ascii_framer import dsdaf_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  sample_t sample_i,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned VALUE_BITS = SAMPLE_BITS + 1;

  logic [SAMPLE_BITS-1:0] samp_a, samp_b;
  logic [VALUE_BITS-1:0]  value_a, value_b;
  logic                   load, take, frame_ready;
  logic                   full_a, full_b;
  lane_stat_t             stat_a, stat_b;

  assign samp_a  = SAMPLE_BITS'(sample_i.first_sample);
  assign samp_b  = SAMPLE_BITS'(sample_i.second_sample);
  assign value_a = VALUE_BITS'(samp_a);
  // second channel is printed doubled
  assign value_b = {samp_b, 1'b0};

  assign busy = full_a || full_b;
  assign load = start && !busy;
  assign take = stat_a.done && stat_b.done && frame_ready;

  dsdaf_lane #(
    .VALUE_BITS(VALUE_BITS)
  ) u_lane_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .value_i(value_a),
    .take_i (take),
    .full_o (full_a),
    .stat_o (stat_a)
  );

  dsdaf_lane #(
    .VALUE_BITS(VALUE_BITS)
  ) u_lane_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .value_i(value_b),
    .take_i (take),
    .full_o (full_b),
    .stat_o (stat_b)
  );

  dsdaf_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .lane_a_i      (stat_a),
    .lane_b_i      (stat_b),
    .ready_o       (frame_ready),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dsdaf_pkg::*;

  localparam int unsigned SAMPLE_BITS  = 10;
  localparam int unsigned DRAIN_CYCLES = SAMPLE_BITS + 3 + MSG_LEN + 12;
  localparam int unsigned RAND_PER_PHASE = 50;
  localparam int unsigned N_DIRECTED   = 16;
  localparam int unsigned N_CORNERS    = 14;
  localparam int unsigned CORNER_VAL[N_CORNERS] =
    '{0, 1, 9, 10, 99, 100, 499, 500, 511, 512, 999, 1000, 1022, 1023};

  typedef struct {
    sample_t      smp;
    bit           fixed;  // text below is the known message
    logic [127:0] text;
  } pair_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  sample_t sample_i;
  logic    result_valid_o;
  result_t result_o;

  result_t   pending_chars[$];
  result_t   want_chr;
  int        errors;
  pair_row_t pair_rows[N_DIRECTED];

  dual_sample_decimal_ascii_framer #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .sample_i      (sample_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  // four ascii digits, thousands first
  function automatic logic [31:0] decimal_chars(int unsigned value);
    int unsigned rest;
    int unsigned div;
    logic [31:0] chars;
    rest  = value;
    div   = 1000;
    chars = '0;
    for (int i = 0; i < 4; i++) begin
      chars = {chars[23:0], CHAR_ZERO + 8'(rest / div)};
      rest  = rest % div;
      div   = div / 10;
    end
    return chars;
  endfunction

  function automatic logic [127:0] format_message(sample_t smp);
    int unsigned ch1;
    int unsigned ch2;
    ch1 = int'(smp.first_sample) & ((1 << SAMPLE_BITS) - 1);
    ch2 = (int'(smp.second_sample) & ((1 << SAMPLE_BITS) - 1)) * 2;
    return {CHAR_AT, CHAR_S, CHAR_P, CHAR_S, CHAR_SPACE, decimal_chars(ch1),
            CHAR_SPACE, decimal_chars(ch2), CHAR_CR, CHAR_LF};
  endfunction

  function automatic sample_t random_pair();
    sample_t smp;
    smp.first_sample  = ($urandom_range(0, 5) == 0) ?
                        FIELD_W'(CORNER_VAL[$urandom_range(0, N_CORNERS - 1)]) :
                        FIELD_W'($urandom_range(0, 1023));
    smp.second_sample = ($urandom_range(0, 5) == 0) ?
                        FIELD_W'(CORNER_VAL[$urandom_range(0, N_CORNERS - 1)]) :
                        FIELD_W'($urandom_range(0, 1023));
    return smp;
  endfunction

  task automatic queue_message(input logic [127:0] text);
    result_t chr;
    for (int k = 0; k < MSG_LEN; k++) begin
      chr.out_byte       = text[127 - 8 * k -: 8];
      chr.end_of_message = (k == MSG_LEN - 1);
      pending_chars.push_back(chr);
    end
  endtask

  // called at a rising edge; returns at the edge that takes the transfer
  task automatic send_pair(input sample_t smp, input logic [127:0] text);
    start    <= 1'b1;
    sample_i <= smp;
    do @(posedge clk_i); while (busy);
    queue_message(text);
  endtask

  task automatic sender_gap(input int unsigned pct);
    if ($urandom_range(0, 99) < pct) begin
      start    <= 1'b0;
      sample_i <= sample_t'($urandom_range(0, (1 << (2 * FIELD_W)) - 1));
      @(posedge clk_i);
      while ($urandom_range(0, 99) < pct) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected byte %h eom %b", result_o.out_byte, result_o.end_of_message);
        errors++;
      end else begin
        want_chr = pending_chars.pop_front();
        if (result_o.out_byte !== want_chr.out_byte) begin
          $error("out_byte: expected %h, got %h", want_chr.out_byte, result_o.out_byte);
          errors++;
        end
        if (result_o.end_of_message !== want_chr.end_of_message) begin
          $error("end_of_message: expected %b, got %b",
                 want_chr.end_of_message, result_o.end_of_message);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_pct[3];
    sample_t     smp;
    logic [127:0] text;

    idle_pct = '{7, 81, 0};
    errors   = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    sample_i = '0;

    pair_rows = '{
      '{'{10'd0,    10'd0},    1'b1, "@SPS 0000 0000\015\012"},
      '{'{10'd1023, 10'd1023}, 1'b1, "@SPS 1023 2046\015\012"},
      '{'{10'd1023, 10'd0},    1'b1, "@SPS 1023 0000\015\012"},
      '{'{10'd0,    10'd1023}, 1'b1, "@SPS 0000 2046\015\012"},
      '{'{10'd1,    10'd1},    1'b1, "@SPS 0001 0002\015\012"},
      '{'{10'd1000, 10'd500},  1'b1, "@SPS 1000 1000\015\012"},
      '{'{10'd999,  10'd499},  1'b0, '0},
      '{'{10'd512,  10'd512},  1'b0, '0},
      '{'{10'h2AA,  10'h155},  1'b0, '0},
      '{'{10'h155,  10'h2AA},  1'b0, '0},
      '{'{10'd9,    10'd5},    1'b0, '0},
      '{'{10'd10,   10'd50},   1'b0, '0},
      '{'{10'd99,   10'd499},  1'b0, '0},
      '{'{10'd100,  10'd999},  1'b0, '0},
      '{'{10'd511,  10'd511},  1'b0, '0},
      '{'{10'd1022, 10'd1},    1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pair_rows[i]) begin
      text = pair_rows[i].fixed ? pair_rows[i].text : format_message(pair_rows[i].smp);
      send_pair(pair_rows[i].smp, text);
      sender_gap(7);
    end

    for (int phase = 0; phase < 3; phase++) begin
      // let the block run dry before each phase
      wait_drained();
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        smp = random_pair();
        send_pair(smp, format_message(smp));
        sender_gap(idle_pct[phase]);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
